### src/psc_pkg.sv
// Package for the panel input scanner: sizes, event codes and the key matrix map.
// Used by the scanner, its checker and the testbench.
package psc_pkg;

  localparam int SW_COUNT      = 3;
  localparam int KEY_COUNT     = 17;
  localparam int COL_COUNT     = 7;
  localparam int EV_KEY_BASE   = SW_COUNT + 1;
  localparam int EV_SLOTS      = EV_KEY_BASE + COL_COUNT;
  localparam int EV_SLOT_W     = $clog2(EV_SLOTS);

  localparam logic [7:0] ADC_PERIOD_RESET = 8'd20;

  typedef enum logic [2:0] {
    EV_SW_DOWN  = 3'd0,
    EV_SW_UP    = 3'd1,
    EV_ENC      = 3'd2,
    EV_KEY_DOWN = 3'd3,
    EV_KEY_UP   = 3'd4
  } ev_kind_e;

  // Results waiting for delivery, one slot per possible event of a tick.
  typedef struct packed {
    logic [EV_SLOTS-1:0] mask;
    logic [EV_SLOTS-1:0] up;
    logic signed [1:0]   dir;
    logic [1:0]          row;
    logic [2:0]          drive;
    logic                adc;
  } pend_t;

  function automatic logic [1:0] key_row(input int k);
    logic [1:0] r;
    if (k < 5) begin
      r = 2'd1;
    end else if (k < 10) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [2:0] key_col(input int k);
    logic [2:0] c;
    case (k)
      0, 5, 10: c = 3'd0;
      1, 6, 11: c = 3'd1;
      2, 7, 12: c = 3'd2;
      3, 13:    c = 3'd3;
      8, 14:    c = 3'd4;
      4, 15:    c = 3'd5;
      9, 16:    c = 3'd6;
      default:  c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] key_index(input logic [1:0] row, input logic [2:0] col);
    logic [4:0] k;
    k = 5'd0;
    case (row)
      2'd1: begin
        case (col)
          3'd0:    k = 5'd0;
          3'd1:    k = 5'd1;
          3'd2:    k = 5'd2;
          3'd3:    k = 5'd3;
          3'd5:    k = 5'd4;
          default: k = 5'd0;
        endcase
      end
      2'd2: begin
        case (col)
          3'd0:    k = 5'd5;
          3'd1:    k = 5'd6;
          3'd2:    k = 5'd7;
          3'd4:    k = 5'd8;
          3'd6:    k = 5'd9;
          default: k = 5'd0;
        endcase
      end
      2'd3: begin
        k = 5'd10 + {2'b00, col};
      end
      default: k = 5'd0;
    endcase
    return k;
  endfunction

endpackage

### src/psc_if.sv
// Request channels of the panel input scanner: tick input, result output, config write.
// Plain valid/ready interfaces; no package dependency.
interface psc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] tact_n;
  logic       enc_a_n;
  logic       enc_b_n;
  logic [6:0] col_n;

  modport source (output valid, tact_n, enc_a_n, enc_b_n, col_n, input ready);
  modport sink   (input valid, tact_n, enc_a_n, enc_b_n, col_n, output ready);
endinterface

interface psc_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        row_drive_n;
  logic              adc_start;
  logic              event_valid;
  logic [2:0]        event_kind;
  logic [4:0]        event_index;
  logic signed [1:0] direction;
  logic              last;

  modport source (output valid, row_drive_n, adc_start, event_valid, event_kind,
                  event_index, direction, last, input ready);
  modport sink   (input valid, row_drive_n, adc_start, event_valid, event_kind,
                  event_index, direction, last, output ready);
endinterface

interface psc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] adc_period;

  modport source (output valid, adc_period, input ready);
  modport sink   (input valid, adc_period, output ready);
endinterface

### src/panel_input_scanner.sv
// Panel input scanner top level: debounce, quadrature decode, key matrix scan, ADC pacing.
// Depends on psc_pkg and the channel interfaces in psc_if.sv.

// Each input request is one timer tick; drive and sample ticks alternate. A tick is
// evaluated in the cycle it is accepted and its events (switches, encoder, then keys of
// the scanned row) are queued in a pending register, from which one result per cycle
// moves into the output register unless the output stalls. A tick has 1 to 11 results;
// the next tick is accepted in the same cycle the previous tick's last result enters
// the output register, so event-free ticks stream at one per cycle when the output does
// not stall. Results pass through the pending register, then the output register.
// Configuration writes are always ready.
module panel_input_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  psc_in_if.sink      in_i,
  psc_out_if.source   out_o,
  psc_cfg_if.sink     cfg_i
);
  import psc_pkg::*;

  typedef enum logic [2:0] {
    ROT_IDLE = 3'd0,
    ROT_A_LO = 3'd1,
    ROT_B_LO = 3'd2,
    ROT_A_HI = 3'd3,
    ROT_B_HI = 3'd4
  } rot_e;

  logic              phase_q, phase_d;
  logic [1:0]        scan_row_q, scan_row_d;
  logic [3:0]        sw_hist_q [SW_COUNT];
  logic [3:0]        sw_hist_d [SW_COUNT];
  logic [1:0]        sw_slot_q, sw_slot_d;
  logic [SW_COUNT-1:0] sw_lvl_q, sw_lvl_d;
  logic [3:0]        pin_hist_q [2];
  logic [3:0]        pin_hist_d [2];
  logic [1:0]        pin_slot_q, pin_slot_d;
  logic [1:0]        pin_lvl_q, pin_lvl_d;
  rot_e              rot_q, rot_d;
  logic [1:0]        key_hist_q [KEY_COUNT];
  logic [1:0]        key_hist_d [KEY_COUNT];
  logic              key_slot_q, key_slot_d;
  logic [KEY_COUNT-1:0] key_lvl_q, key_lvl_d;
  logic [7:0]        tick_q, tick_d;
  logic [7:0]        period_q;

  pend_t             pend_q, pend_d, pend_new;
  logic              pend_v_q, pend_v_d;

  logic              out_v_q;
  logic [2:0]        out_drive_q;
  logic              out_adc_q;
  logic              out_ev_q;
  ev_kind_e          out_kind_q;
  logic [4:0]        out_idx_q;
  logic signed [1:0] out_dir_q;
  logic              out_last_q;

  logic              acc;
  logic              out_load;
  logic [EV_SLOTS-1:0] rest_mask;
  logic [EV_SLOT_W-1:0] sel;
  logic [2:0]        sel_col;
  logic              sel_ev;
  ev_kind_e          sel_kind;
  logic [4:0]        sel_idx;
  logic signed [1:0] sel_dir;
  logic [7:0]        tick_inc;

  // ---------------- tick evaluation ----------------
  always_comb begin
    logic [3:0] h;
    logic [1:0] kh;
    logic       both_on;
    logic       both_off;
    phase_d    = phase_q;
    scan_row_d = scan_row_q;
    sw_hist_d  = sw_hist_q;
    sw_slot_d  = sw_slot_q;
    sw_lvl_d   = sw_lvl_q;
    pin_hist_d = pin_hist_q;
    pin_slot_d = pin_slot_q;
    pin_lvl_d  = pin_lvl_q;
    rot_d      = rot_q;
    key_hist_d = key_hist_q;
    key_slot_d = key_slot_q;
    key_lvl_d  = key_lvl_q;
    pend_new   = '0;
    h          = '0;
    kh         = '0;
    both_on    = 1'b0;
    both_off   = 1'b0;

    pend_new.row   = scan_row_q;
    pend_new.drive = 3'b111;
    if (scan_row_q != 2'd0) begin
      pend_new.drive[scan_row_q - 2'd1] = 1'b0;
    end

    tick_inc = tick_q + 8'd1;
    pend_new.adc = (tick_inc >= period_q);
    tick_d = pend_new.adc ? 8'd0 : tick_inc;

    if (!phase_q) begin
      phase_d = 1'b1;
    end else begin
      phase_d = 1'b0;

      for (int i = 0; i < SW_COUNT; i++) begin
        h = sw_hist_q[i];
        h[sw_slot_q] = ~in_i.tact_n[i];
        sw_hist_d[i] = h;
        if (!sw_lvl_q[i] && h == 4'hF) begin
          sw_lvl_d[i] = 1'b1;
          pend_new.mask[i] = 1'b1;
        end else if (sw_lvl_q[i] && h == 4'h0) begin
          sw_lvl_d[i] = 1'b0;
          pend_new.mask[i] = 1'b1;
          pend_new.up[i] = 1'b1;
        end
      end
      sw_slot_d = sw_slot_q + 2'd1;

      // pin 0 is A, pin 1 is B
      pin_hist_d[0][pin_slot_q] = ~in_i.enc_a_n;
      pin_hist_d[1][pin_slot_q] = ~in_i.enc_b_n;
      for (int p = 0; p < 2; p++) begin
        if (!pin_lvl_q[p] && pin_hist_d[p] == 4'hF) begin
          pin_lvl_d[p] = 1'b1;
        end else if (pin_lvl_q[p] && pin_hist_d[p] == 4'h0) begin
          pin_lvl_d[p] = 1'b0;
        end
      end
      pin_slot_d = pin_slot_q + 2'd1;

      if (pin_lvl_q == 2'b00) begin
        if (pin_lvl_d == 2'b01) begin
          rot_d = ROT_A_LO;
        end else if (pin_lvl_d == 2'b10) begin
          rot_d = ROT_B_LO;
        end
      end else if (pin_lvl_q == 2'b11) begin
        if (pin_lvl_d == 2'b01) begin
          rot_d = ROT_A_HI;
        end else if (pin_lvl_d == 2'b10) begin
          rot_d = ROT_B_HI;
        end
      end
      both_on  = (pin_lvl_d == 2'b11);
      both_off = (pin_lvl_d == 2'b00);
      case (rot_d)
        ROT_A_LO, ROT_B_LO: begin
          if (both_on) begin
            pend_new.mask[SW_COUNT] = 1'b1;
            pend_new.dir = (rot_d == ROT_A_LO) ? 2'sd1 : -2'sd1;
            rot_d = ROT_IDLE;
          end else if (both_off) begin
            rot_d = ROT_IDLE;
          end
        end
        ROT_A_HI, ROT_B_HI: begin
          if (both_off) begin
            pend_new.mask[SW_COUNT] = 1'b1;
            pend_new.dir = (rot_d == ROT_A_HI) ? -2'sd1 : 2'sd1;
            rot_d = ROT_IDLE;
          end else if (both_on) begin
            rot_d = ROT_IDLE;
          end
        end
        default: begin
        end
      endcase

      if (scan_row_q != 2'd0) begin
        for (int k = 0; k < KEY_COUNT; k++) begin
          if (key_row(k) == scan_row_q) begin
            kh = key_hist_q[k];
            kh[key_slot_q] = ~in_i.col_n[key_col(k)];
            key_hist_d[k] = kh;
            if (!key_lvl_q[k] && kh == 2'b11) begin
              key_lvl_d[k] = 1'b1;
              pend_new.mask[EV_KEY_BASE + int'(key_col(k))] = 1'b1;
            end else if (key_lvl_q[k] && kh == 2'b00) begin
              key_lvl_d[k] = 1'b0;
              pend_new.mask[EV_KEY_BASE + int'(key_col(k))] = 1'b1;
              pend_new.up[EV_KEY_BASE + int'(key_col(k))] = 1'b1;
            end
          end
        end
        if (scan_row_q == 2'd3) begin
          scan_row_d = 2'd1;
          key_slot_d = ~key_slot_q;
        end else begin
          scan_row_d = scan_row_q + 2'd1;
        end
      end else begin
        scan_row_d = 2'd2;
      end
    end
  end

  // ---------------- result selection ----------------
  always_comb begin
    sel = '0;
    for (int i = EV_SLOTS - 1; i >= 0; i--) begin
      if (pend_q.mask[i]) begin
        sel = EV_SLOT_W'(i);
      end
    end
    rest_mask = pend_q.mask & (pend_q.mask - EV_SLOTS'(1));
    sel_col   = 3'(sel - EV_SLOT_W'(EV_KEY_BASE));
    sel_ev    = (pend_q.mask != '0);
    sel_kind  = EV_SW_DOWN;
    sel_idx   = 5'd0;
    sel_dir   = 2'sd0;
    if (sel_ev) begin
      if (sel < EV_SLOT_W'(SW_COUNT)) begin
        sel_kind = pend_q.up[sel] ? EV_SW_UP : EV_SW_DOWN;
        sel_idx  = 5'(sel);
      end else if (sel == EV_SLOT_W'(SW_COUNT)) begin
        sel_kind = EV_ENC;
        sel_dir  = pend_q.dir;
      end else begin
        sel_kind = pend_q.up[sel] ? EV_KEY_UP : EV_KEY_DOWN;
        sel_idx  = key_index(pend_q.row, sel_col);
      end
    end
  end

  assign out_load = pend_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !pend_v_q || (out_load && rest_mask == '0);
  assign acc = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    if (acc) begin
      pend_d   = pend_new;
      pend_v_d = 1'b1;
    end else if (out_load) begin
      pend_d.mask = rest_mask;
      pend_v_d    = (rest_mask != '0);
    end
  end

  // ---------------- state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      scan_row_q <= 2'd1;
      sw_slot_q  <= '0;
      sw_lvl_q   <= '0;
      pin_slot_q <= '0;
      pin_lvl_q  <= '0;
      rot_q      <= ROT_IDLE;
      key_slot_q <= 1'b0;
      key_lvl_q  <= '0;
      tick_q     <= '0;
      period_q   <= ADC_PERIOD_RESET;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      for (int i = 0; i < SW_COUNT; i++) begin
        sw_hist_q[i] <= '0;
      end
      for (int p = 0; p < 2; p++) begin
        pin_hist_q[p] <= '0;
      end
      for (int k = 0; k < KEY_COUNT; k++) begin
        key_hist_q[k] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        period_q <= cfg_i.adc_period;
      end
      if (acc) begin
        phase_q    <= phase_d;
        scan_row_q <= scan_row_d;
        sw_hist_q  <= sw_hist_d;
        sw_slot_q  <= sw_slot_d;
        sw_lvl_q   <= sw_lvl_d;
        pin_hist_q <= pin_hist_d;
        pin_slot_q <= pin_slot_d;
        pin_lvl_q  <= pin_lvl_d;
        rot_q      <= rot_d;
        key_hist_q <= key_hist_d;
        key_slot_q <= key_slot_d;
        key_lvl_q  <= key_lvl_d;
        tick_q     <= tick_d;
      end
      pend_v_q <= pend_v_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_drive_q <= pend_q.drive;
      out_adc_q   <= pend_q.adc;
      out_ev_q    <= sel_ev;
      out_kind_q  <= sel_kind;
      out_idx_q   <= sel_idx;
      out_dir_q   <= sel_dir;
      out_last_q  <= (rest_mask == '0);
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.row_drive_n = out_drive_q;
  assign out_o.adc_start   = out_adc_q;
  assign out_o.event_valid = out_ev_q;
  assign out_o.event_kind  = out_kind_q;
  assign out_o.event_index = out_idx_q;
  assign out_o.direction   = out_dir_q;
  assign out_o.last        = out_last_q;

endmodule

### src/psc_checker.sv
// Port-level checker for the panel input scanner, bound to the top level.
// Depends on psc_pkg for the event codes.
module psc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [2:0]        row_drive_n_i,
  input logic              adc_start_i,
  input logic              event_valid_i,
  input logic [2:0]        event_kind_i,
  input logic [4:0]        event_index_i,
  input logic signed [1:0] direction_i,
  input logic              last_i
);
  import psc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_kind_i)
      && $stable(event_index_i) && $stable(last_i) && $stable(adc_start_i))
    else $error("result changed while stalled");

  a_null_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !event_valid_i |-> last_i && event_kind_i == EV_SW_DOWN
      && event_index_i == 5'd0 && direction_i == 2'sd0)
    else $error("empty result not alone or not cleared");

  a_dir_encoder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && direction_i != 2'sd0 |-> event_valid_i && event_kind_i == EV_ENC)
    else $error("direction on a non-encoder result");

  a_one_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $countones(~row_drive_n_i) <= 1)
    else $error("more than one row driven");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("gap inside a tick's results");

endmodule

bind panel_input_scanner psc_checker u_psc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .row_drive_n_i (out_o.row_drive_n),
  .adc_start_i   (out_o.adc_start),
  .event_valid_i (out_o.event_valid),
  .event_kind_i  (out_o.event_kind),
  .event_index_i (out_o.event_index),
  .direction_i   (out_o.direction),
  .last_i        (out_o.last)
);

### tb/sv/testbench.sv
// Self-checking bench for panel_input_scanner: random and directed ticks with stalls,
// an in-bench predictor of debounce, quadrature and key-scan events, and a scoreboard.
// Depends on psc_pkg, the channel interfaces in psc_if.sv and the scanner top level.
`timescale 1ns / 1ps

module testbench;
  import psc_pkg::*;

  localparam int LONG_HOLD        = 300;
  localparam int SETTLE           = 8;
  localparam int DIRECTED_TICKS   = 24;
  localparam int RANDOM_PER_PHASE = 64;
  localparam int PHASES           = 6;

  localparam logic signed [1:0] STEP_UP   = 2'sd1;
  localparam logic signed [1:0] STEP_DOWN = -2'sd1;

  typedef enum logic [2:0] {
    ROT_IDLE,
    ROT_A_FROM_OFF,
    ROT_B_FROM_OFF,
    ROT_A_FROM_ON,
    ROT_B_FROM_ON
  } rot_phase_e;

  typedef struct packed {
    logic [2:0]        drive;
    logic              adc;
    logic              ev_valid;
    logic [2:0]        kind;
    logic [4:0]        idx;
    logic signed [1:0] dir;
    logic              last;
  } scan_result_t;

  class tick_scoreboard;
    scan_result_t expected_q[$];
    scan_result_t tick_q[$];
    int unsigned  failures;
    logic [7:0]   adc_period;
    logic [7:0]   tick_count;
    bit           sample_tick;
    logic [1:0]   scan_row;
    logic [3:0]   sw_hist [SW_COUNT];
    bit           sw_level [SW_COUNT];
    logic [1:0]   sw_slot;
    logic [3:0]   pin_hist [2];
    bit           pin_level [2];
    logic [1:0]   pin_slot;
    rot_phase_e   rot;
    logic [1:0]   key_hist [KEY_COUNT];
    bit           key_level [KEY_COUNT];
    bit           key_slot;

    function new();
      failures    = 0;
      adc_period  = ADC_PERIOD_RESET;
      tick_count  = '0;
      sample_tick = 1'b0;
      scan_row    = 2'd1;
      sw_slot     = '0;
      pin_slot    = '0;
      key_slot    = 1'b0;
      rot         = ROT_IDLE;
      foreach (sw_hist[i]) begin
        sw_hist[i]  = '0;
        sw_level[i] = 1'b0;
      end
      foreach (pin_hist[i]) begin
        pin_hist[i]  = '0;
        pin_level[i] = 1'b0;
      end
      foreach (key_hist[i]) begin
        key_hist[i]  = '0;
        key_level[i] = 1'b0;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void set_period(logic [7:0] p);
      adc_period = p;
    endfunction

    // key number wired at a row (1..3) and column, -1 where nothing is wired
    function int key_at(int row, int col);
      case (row)
        1: begin
          case (col)
            0, 1, 2, 3: return col;
            5:          return 4;
            default:    return -1;
          endcase
        end
        2: begin
          case (col)
            0, 1, 2: return 5 + col;
            4:       return 8;
            6:       return 9;
            default: return -1;
          endcase
        end
        3:       return 10 + col;
        default: return -1;
      endcase
    endfunction

    function void add_event(ev_kind_e kind, int idx, logic signed [1:0] dir);
      scan_result_t r;
      r          = '0;
      r.ev_valid = 1'b1;
      r.kind     = kind;
      r.idx      = idx[4:0];
      r.dir      = dir;
      tick_q.push_back(r);
    endfunction

    function void note_tick(logic [2:0] tact_n, logic a_n, logic b_n, logic [6:0] col_n);
      scan_result_t r;
      logic [2:0]   drive;
      bit           adc;
      bit           was_a, was_b, pa, pb, both_on, both_off;
      int           i, k;
      drive = (scan_row != 2'd0) ? ~(3'd1 << (scan_row - 2'd1)) : 3'b111;
      tick_q.delete();
      if (!sample_tick) begin
        sample_tick = 1'b1;
      end else begin
        for (i = 0; i < SW_COUNT; i++) begin
          sw_hist[i][sw_slot] = ~tact_n[i];
          if (!sw_level[i] && (&sw_hist[i])) begin
            sw_level[i] = 1'b1;
            add_event(EV_SW_DOWN, i, 2'sd0);
          end else if (sw_level[i] && !(|sw_hist[i])) begin
            sw_level[i] = 1'b0;
            add_event(EV_SW_UP, i, 2'sd0);
          end
        end
        sw_slot = sw_slot + 2'd1;

        pin_hist[0][pin_slot] = ~a_n;
        pin_hist[1][pin_slot] = ~b_n;
        was_a = pin_level[0];
        was_b = pin_level[1];
        for (i = 0; i < 2; i++) begin
          if (!pin_level[i] && (&pin_hist[i])) begin
            pin_level[i] = 1'b1;
          end else if (pin_level[i] && !(|pin_hist[i])) begin
            pin_level[i] = 1'b0;
          end
        end
        pa = pin_level[0];
        pb = pin_level[1];
        if (!was_a && !was_b) begin
          if (pa && !pb) begin
            rot = ROT_A_FROM_OFF;
          end else if (!pa && pb) begin
            rot = ROT_B_FROM_OFF;
          end
        end else if (was_a && was_b) begin
          if (pa && !pb) begin
            rot = ROT_A_FROM_ON;
          end else if (!pa && pb) begin
            rot = ROT_B_FROM_ON;
          end
        end
        both_on  = pa && pb;
        both_off = !pa && !pb;
        case (rot)
          ROT_A_FROM_OFF: begin
            if (both_on) begin
              add_event(EV_ENC, 0, STEP_UP);
              rot = ROT_IDLE;
            end else if (both_off) begin
              rot = ROT_IDLE;
            end
          end
          ROT_B_FROM_OFF: begin
            if (both_on) begin
              add_event(EV_ENC, 0, STEP_DOWN);
              rot = ROT_IDLE;
            end else if (both_off) begin
              rot = ROT_IDLE;
            end
          end
          ROT_A_FROM_ON: begin
            if (both_off) begin
              add_event(EV_ENC, 0, STEP_DOWN);
              rot = ROT_IDLE;
            end else if (both_on) begin
              rot = ROT_IDLE;
            end
          end
          ROT_B_FROM_ON: begin
            if (both_off) begin
              add_event(EV_ENC, 0, STEP_UP);
              rot = ROT_IDLE;
            end else if (both_on) begin
              rot = ROT_IDLE;
            end
          end
          default: begin
          end
        endcase
        pin_slot = pin_slot + 2'd1;

        if (scan_row != 2'd0) begin
          for (i = 0; i < COL_COUNT; i++) begin
            k = key_at(scan_row, i);
            if (k >= 0 && k < KEY_COUNT) begin
              key_hist[k][key_slot] = ~col_n[i];
              if (!key_level[k] && (&key_hist[k])) begin
                key_level[k] = 1'b1;
                add_event(EV_KEY_DOWN, k, 2'sd0);
              end else if (key_level[k] && !(|key_hist[k])) begin
                key_level[k] = 1'b0;
                add_event(EV_KEY_UP, k, 2'sd0);
              end
            end
          end
          if (scan_row == 2'd3) begin
            scan_row = 2'd1;
            key_slot = ~key_slot;
          end else begin
            scan_row = scan_row + 2'd1;
          end
        end else begin
          scan_row = 2'd2;
        end
        sample_tick = 1'b0;
      end

      tick_count = tick_count + 8'd1;
      adc = 1'b0;
      if (tick_count >= adc_period) begin
        adc        = 1'b1;
        tick_count = '0;
      end

      if (tick_q.size() == 0) begin
        r = '0;
        tick_q.push_back(r);
      end
      for (i = 0; i < tick_q.size(); i++) begin
        r       = tick_q[i];
        r.drive = drive;
        r.adc   = adc;
        r.last  = (i == tick_q.size() - 1);
        expected_q.push_back(r);
      end
    endfunction

    function void field_check(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d index %0d", got.kind, got.idx);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      field_check("row_drive_n", want.drive, got.drive);
      field_check("adc_start", want.adc, got.adc);
      field_check("event_valid", want.ev_valid, got.ev_valid);
      field_check("event_kind", want.kind, got.kind);
      field_check("event_index", want.idx, got.idx);
      field_check("direction", $signed(want.dir), $signed(got.dir));
      field_check("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_stall_pct;
  bit   rx_hold;
  event hold_go;

  tick_scoreboard sb;

  psc_in_if  tick_ch ();
  psc_out_if result_ch ();
  psc_cfg_if cfg_ch ();

  panel_input_scanner dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_ch),
    .out_o  (result_ch),
    .cfg_i  (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    @(hold_go);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (result_ch.valid && result_ch.ready) begin
        sb.check_result('{drive: result_ch.row_drive_n, adc: result_ch.adc_start,
                          ev_valid: result_ch.event_valid, kind: result_ch.event_kind,
                          idx: result_ch.event_index, dir: result_ch.direction,
                          last: result_ch.last});
      end
    end
    result_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send_tick(logic [2:0] tact_n, logic a_n, logic b_n, logic [6:0] col_n);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.tact_n  <= tact_n;
    tick_ch.enc_a_n <= a_n;
    tick_ch.enc_b_n <= b_n;
    tick_ch.col_n   <= col_n;
    do @(posedge clk); while (!tick_ch.ready);
    sb.note_tick(tact_n, a_n, b_n, col_n);
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_period(logic [7:0] p);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.adc_period <= p;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_period(p);
  endtask

  // press everything with A leading B, then release all
  task automatic directed_ticks();
    int i;
    for (i = 0; i < DIRECTED_TICKS; i++) begin
      if (i < 8) begin
        send_tick(3'b000, 1'b0, 1'b1, 7'h00);
      end else if (i < 16) begin
        send_tick(3'b000, 1'b0, 1'b0, 7'h00);
      end else begin
        send_tick(3'b111, 1'b1, 1'b1, 7'h7f);
      end
    end
  endtask

  // held input patterns with quadrature steps, plus glitches and noise runs
  task automatic run_random(int count, bit mid_pause);
    int         i, run, enc;
    bit         noisy;
    logic [2:0] sw_n, t;
    logic [6:0] cols, c;
    logic [1:0] pins;
    logic       a, b;
    run   = 0;
    enc   = 0;
    noisy = 1'b0;
    sw_n  = '1;
    cols  = '1;
    for (i = 0; i < count; i++) begin
      if (mid_pause && i == count / 2) wait_drained();
      if (run == 0) begin
        run   = $urandom_range(6, 20);
        noisy = ($urandom_range(9) == 0);
        sw_n  = 3'($urandom);
        cols  = 7'($urandom);
        case ($urandom_range(3))
          0, 1:    enc = (enc + 1) % 4;
          2:       enc = (enc + 3) % 4;
          default: enc = $urandom_range(3);
        endcase
      end
      run--;
      case (enc)
        0:       pins = 2'b00;
        1:       pins = 2'b10;
        2:       pins = 2'b11;
        default: pins = 2'b01;
      endcase
      t = sw_n;
      c = cols;
      a = ~pins[1];
      b = ~pins[0];
      if (noisy || $urandom_range(7) == 0) begin
        t = t ^ 3'($urandom);
        c = c ^ 7'($urandom);
        if ($urandom_range(1)) a = ~a;
        if ($urandom_range(1)) b = ~b;
      end
      send_tick(t, a, b, c);
    end
  endtask

  initial begin
    int p;
    sb                = new();
    tx_idle_pct       = 0;
    rx_stall_pct      <= 0;
    rst_n             <= 1'b0;
    tick_ch.valid     <= 1'b0;
    tick_ch.tact_n    <= '1;
    tick_ch.enc_a_n   <= 1'b1;
    tick_ch.enc_b_n   <= 1'b1;
    tick_ch.col_n     <= '1;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.adc_period <= ADC_PERIOD_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_ticks();

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      repeat (SETTLE) @(posedge clk);
      case (p)
        0:       write_period(8'd1);
        1:       write_period(8'd255);
        2:       write_period(8'd3);
        3:       write_period(8'd0);
        4:       write_period(8'($urandom_range(4, 254)));
        default: write_period(ADC_PERIOD_RESET);
      endcase
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct  = 49;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 49;
        end
        default: begin
          tx_idle_pct  = 13;
          rx_stall_pct <= 13;
        end
      endcase
      if (p == 4) -> hold_go;
      run_random(RANDOM_PER_PHASE, p == 2);
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
